@@ design/rbst_pkg.sv @@
// Shared constants, types and helpers of the rigid body sleep tracker.
package rbst_pkg;

  localparam int unsigned TIME_BITS     = 18;
  localparam int unsigned VEL_BITS      = 16;
  localparam int unsigned STEP_BITS     = 16;
  localparam int unsigned WAKE_BITS     = 15;
  localparam int unsigned CMD_BITS      = 2;
  localparam int unsigned BLEND_BITS    = 16;
  localparam int unsigned BLEND_FRAC    = 15;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = (TIME_BITS > WAKE_BITS) ? TIME_BITS : WAKE_BITS;
  localparam int unsigned MUL_BITS      = (VEL_BITS > WAKE_BITS) ? VEL_BITS : WAKE_BITS;
  localparam int unsigned PROD_BITS     = 2 * MUL_BITS;
  localparam int unsigned SUM_BITS      = PROD_BITS + 2;
  localparam int unsigned SUMT_BITS     = ((TIME_BITS > STEP_BITS) ? TIME_BITS : STEP_BITS) + 1;
  localparam int unsigned LANES         = 3;
  localparam int unsigned DIV_CNT_BITS  = $clog2(BLEND_FRAC);
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned QPTR_BITS     = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS     = $clog2(QDEPTH + 1);

  localparam logic [BLEND_BITS-1:0] BLEND_ONE = {1'b1, {BLEND_FRAC{1'b0}}};

  localparam longint unsigned TIME_MAX   = (64'd1 << TIME_BITS) - 64'd1;
  localparam longint unsigned DEACT_RAW  = 64'd102400;
  localparam logic [TIME_BITS-1:0] DEACT_TIME =
    TIME_BITS'((DEACT_RAW > TIME_MAX) ? TIME_MAX : DEACT_RAW);

  localparam logic                   SLEEP_EN_RST    = 1'b1;
  localparam logic [WAKE_BITS-1:0]   WAKE_SPEED_RST  = WAKE_BITS'(256);
  localparam logic [TIME_BITS-1:0]   BLEND_START_RST = TIME_BITS'(1024);
  localparam logic [TIME_BITS-1:0]   SLEEP_END_RST   = TIME_BITS'(2048);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK       = 2'd0,
    CMD_ACTIVATE   = 2'd1,
    CMD_DEACTIVATE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SLEEP_ENABLE = 3'd0,
    CFG_LINEAR_WAKE  = 3'd1,
    CFG_ANGULAR_WAKE = 3'd2,
    CFG_BLEND_START  = 3'd3,
    CFG_SLEEP_END    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_SUM,
    FR_PUSH
  } fr_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BLEND,
    BK_DIV,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    logic                 sleep_enable;
    logic [WAKE_BITS-1:0] linear_wake_speed;
    logic [WAKE_BITS-1:0] angular_wake_speed;
    logic [TIME_BITS-1:0] blend_start_time;
    logic [TIME_BITS-1:0] sleep_end_time;
  } cfg_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]  cmd;
    logic [STEP_BITS-1:0] step_time;
    logic                 energy;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [VEL_BITS-1:0] vel_mag(input logic signed [VEL_BITS-1:0] v);
    logic [VEL_BITS-1:0] u;
    u = v;
    return v[VEL_BITS-1] ? (~u + VEL_BITS'(1)) : u;
  endfunction

endpackage

@@ design/rbst_if.sv @@
// Request, response and configuration channel interfaces of the sleep tracker.
interface rbst_req_if import rbst_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_BITS-1:0]        cmd;
  logic [STEP_BITS-1:0]       step_time;
  logic signed [VEL_BITS-1:0] lin_vel_x;
  logic signed [VEL_BITS-1:0] lin_vel_y;
  logic signed [VEL_BITS-1:0] lin_vel_z;
  logic signed [VEL_BITS-1:0] ang_vel_x;
  logic signed [VEL_BITS-1:0] ang_vel_y;
  logic signed [VEL_BITS-1:0] ang_vel_z;

  modport source (output valid, cmd, step_time, lin_vel_x, lin_vel_y, lin_vel_z,
                  ang_vel_x, ang_vel_y, ang_vel_z, input ready);
  modport sink (input valid, cmd, step_time, lin_vel_x, lin_vel_y, lin_vel_z,
                ang_vel_x, ang_vel_y, ang_vel_z, output ready);
endinterface

interface rbst_rsp_if import rbst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  is_active;
  logic [BLEND_BITS-1:0] blend;
  logic [TIME_BITS-1:0]  idle_time;

  modport source (output valid, is_active, blend, idle_time, input ready);
  modport sink (input valid, is_active, blend, idle_time, output ready);
endinterface

interface rbst_cfg_if import rbst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/rbst_front.sv @@
// Front end: accepts requests, squares velocities and classifies the motion.
module rbst_front import rbst_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  rbst_req_if.sink      req_i,
  input  q_stat_t       q_stat_i,
  output logic          push_o,
  output qent_t         ent_o
);

  localparam logic [1:0] THR_STEP = 2'(LANES);

  fr_state_e state_q, state_d;

  logic [1:0]                 cnt_q;
  logic [CMD_BITS-1:0]        cmd_q;
  logic [STEP_BITS-1:0]       step_q;
  logic signed [VEL_BITS-1:0] lin_q [LANES];
  logic signed [VEL_BITS-1:0] ang_q [LANES];
  logic [MUL_BITS-1:0]        lin_op [LANES+1];
  logic [MUL_BITS-1:0]        ang_op [LANES+1];
  logic [PROD_BITS-1:0]       lin_prod_q, ang_prod_q;
  logic [PROD_BITS-1:0]       lin_thr_q, ang_thr_q;
  logic [SUM_BITS-1:0]        lin_sum_q, ang_sum_q;
  logic                       prod_vld_q;
  logic [1:0]                 prod_idx_q;
  logic                       accept;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lin_op[i] = MUL_BITS'(vel_mag(lin_q[i]));
      ang_op[i] = MUL_BITS'(vel_mag(ang_q[i]));
    end
    lin_op[LANES] = MUL_BITS'(cfg_i.linear_wake_speed);
    ang_op[LANES] = MUL_BITS'(cfg_i.angular_wake_speed);
  end

  assign accept = req_i.valid && req_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (req_i.valid) state_d = FR_MUL;
      FR_MUL:  if (cnt_q == THR_STEP) state_d = FR_SUM;
      FR_SUM:  state_d = FR_PUSH;
      FR_PUSH: if (!q_stat_i.full) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready     = (state_q == FR_IDLE);
    push_o          = (state_q == FR_PUSH) && !q_stat_i.full;
    ent_o.cmd       = cmd_q;
    ent_o.step_time = step_q;
    ent_o.energy    = (lin_sum_q > SUM_BITS'(lin_thr_q)) ||
                      (ang_sum_q > SUM_BITS'(ang_thr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FR_IDLE;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      prod_vld_q <= (state_q == FR_MUL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= req_i.cmd;
      step_q    <= req_i.step_time;
      lin_q[0]  <= req_i.lin_vel_x;
      lin_q[1]  <= req_i.lin_vel_y;
      lin_q[2]  <= req_i.lin_vel_z;
      ang_q[0]  <= req_i.ang_vel_x;
      ang_q[1]  <= req_i.ang_vel_y;
      ang_q[2]  <= req_i.ang_vel_z;
      cnt_q     <= '0;
      lin_sum_q <= '0;
      ang_sum_q <= '0;
    end else begin
      if (state_q == FR_MUL) begin
        lin_prod_q <= PROD_BITS'(lin_op[cnt_q]) * PROD_BITS'(lin_op[cnt_q]);
        ang_prod_q <= PROD_BITS'(ang_op[cnt_q]) * PROD_BITS'(ang_op[cnt_q]);
        prod_idx_q <= cnt_q;
        cnt_q      <= cnt_q + 2'd1;
      end
      if (prod_vld_q) begin
        if (prod_idx_q == THR_STEP) begin
          lin_thr_q <= lin_prod_q;
          ang_thr_q <= ang_prod_q;
        end else begin
          lin_sum_q <= lin_sum_q + SUM_BITS'(lin_prod_q);
          ang_sum_q <= ang_sum_q + SUM_BITS'(ang_prod_q);
        end
      end
    end
  end

endmodule

@@ design/rbst_queue.sv @@
// Two-entry queue between the front and back ends.
module rbst_queue import rbst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  qent_t   ent_i,
  input  logic    pop_i,
  output qent_t   ent_o,
  output q_stat_t stat_o
);

  qent_t                mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;

  assign ent_o        = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == QCNT_BITS'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_BITS'(1);
      if (pop_i) rd_q <= rd_q + QPTR_BITS'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= ent_i;
  end

endmodule

@@ design/rbst_back.sv @@
// Back end: updates the inactive time, divides out the blend and holds the response.
module rbst_back import rbst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  qent_t     ent_i,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  rbst_rsp_if.source rsp_o
);

  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(BLEND_FRAC - 1);

  bk_state_e state_q, state_d;

  logic [TIME_BITS-1:0]    time_q, time_d;
  logic                    active_q, active_d;
  logic [TIME_BITS-1:0]    rem_q, den_q;
  logic [BLEND_FRAC-1:0]   quo_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [BLEND_BITS-1:0]   blend_q;
  logic                    use_div_q;
  logic                    out_vld_q;
  logic                    out_act_q;
  logic [BLEND_BITS-1:0]   out_blend_q;
  logic [TIME_BITS-1:0]    out_time_q;

  logic [SUMT_BITS-1:0]    time_w, step_w, end_w, sum_w;
  logic [TIME_BITS:0]      rem2;
  logic                    in_ramp, out_free, load;

  // time recurrence
  always_comb begin
    time_w   = SUMT_BITS'(time_q);
    step_w   = SUMT_BITS'(ent_i.step_time);
    end_w    = SUMT_BITS'(cfg_i.sleep_end_time);
    sum_w    = time_w + step_w;
    time_d   = time_q;
    active_d = active_q;
    case (ent_i.cmd)
      CMD_TICK: begin
        if (!cfg_i.sleep_enable) begin
          time_d   = '0;
          active_d = 1'b1;
        end else begin
          if (ent_i.energy) begin
            time_d = (time_w > step_w) ? TIME_BITS'(time_w - step_w) : '0;
          end else begin
            time_d = (sum_w > end_w) ? cfg_i.sleep_end_time : TIME_BITS'(sum_w);
          end
          active_d = (time_d < cfg_i.sleep_end_time);
        end
      end
      CMD_ACTIVATE: begin
        time_d   = '0;
        active_d = 1'b1;
      end
      CMD_DEACTIVATE: begin
        time_d   = DEACT_TIME;
        active_d = 1'b0;
      end
      default: ;
    endcase
  end

  assign in_ramp  = (time_q > cfg_i.blend_start_time) && (time_q < cfg_i.sleep_end_time);
  assign rem2     = {rem_q, 1'b0};
  assign out_free = !out_vld_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (!q_stat_i.empty) state_d = BK_BLEND;
      BK_BLEND: state_d = in_ramp ? BK_DIV : BK_OUT;
      BK_DIV:   if (cnt_q == DIV_LAST) state_d = BK_OUT;
      BK_OUT:   if (out_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o           = (state_q == BK_IDLE) && !q_stat_i.empty;
    load            = (state_q == BK_OUT) && out_free;
    rsp_o.valid     = out_vld_q;
    rsp_o.is_active = out_act_q;
    rsp_o.blend     = out_blend_q;
    rsp_o.idle_time = out_time_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      time_q    <= '0;
      active_q  <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        time_q   <= time_d;
        active_q <= active_d;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_BLEND: begin
        use_div_q <= in_ramp;
        blend_q   <= (time_q <= cfg_i.blend_start_time) ? BLEND_ONE : '0;
        rem_q     <= time_q - cfg_i.blend_start_time;
        den_q     <= cfg_i.sleep_end_time - cfg_i.blend_start_time;
        quo_q     <= '0;
        cnt_q     <= '0;
      end
      BK_DIV: begin
        if (rem2 >= {1'b0, den_q}) begin
          rem_q <= TIME_BITS'(rem2 - {1'b0, den_q});
          quo_q <= {quo_q[BLEND_FRAC-2:0], 1'b1};
        end else begin
          rem_q <= TIME_BITS'(rem2);
          quo_q <= {quo_q[BLEND_FRAC-2:0], 1'b0};
        end
        cnt_q <= cnt_q + DIV_CNT_BITS'(1);
      end
      default: ;
    endcase
    if (load) begin
      out_act_q   <= active_q;
      out_blend_q <= use_div_q ? (BLEND_ONE - BLEND_BITS'(quo_q)) : blend_q;
      out_time_q  <= time_q;
    end
  end

endmodule

@@ design/rigid_body_sleep_tracker_unit.sv @@
// Top level of the rigid body sleep tracker: configuration registers and the front/back pipeline.
//
// Usage: each request on req_i carries a command (tick, activate, deactivate),
// a time step and the linear and angular velocity vectors of one body. Every
// request yields exactly one response on rsp_o with the active flag, the
// activity blend (Q1.15) and the inactive time after that request.
// Registers are written over cfg_i (index and data); cfg_i is always ready.
// It must be written only while no request is outstanding; the unit does not enforce this.
// Per request the front end runs four multiply steps on a pair of 16x16
// multipliers, then accumulates and pushes into the queue. The back end runs
// the 15-step restoring divider only when the inactive time sits between the
// blend start and end times. The front end takes a new request only after it
// has pushed the last one into the queue.
// A two-entry queue separates the front end from the back end, and the
// response register lets the next request proceed while a response waits.
// If the receiver stalls, the response holds and the queue fills, then
// req_i.ready drops. Reset clears all control state, makes the body active
// with zero inactive time, and loads the register defaults.
module rigid_body_sleep_tracker_unit import rbst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbst_req_if.sink    req_i,
  rbst_rsp_if.source  rsp_o,
  rbst_cfg_if.sink    cfg_i
);

  cfg_t    cfg_q;
  qent_t   push_ent, pop_ent;
  q_stat_t q_stat;
  logic    push, pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sleep_enable       <= SLEEP_EN_RST;
      cfg_q.linear_wake_speed  <= WAKE_SPEED_RST;
      cfg_q.angular_wake_speed <= WAKE_SPEED_RST;
      cfg_q.blend_start_time   <= BLEND_START_RST;
      cfg_q.sleep_end_time     <= SLEEP_END_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SLEEP_ENABLE: cfg_q.sleep_enable       <= cfg_i.data[0];
        CFG_LINEAR_WAKE:  cfg_q.linear_wake_speed  <= cfg_i.data[WAKE_BITS-1:0];
        CFG_ANGULAR_WAKE: cfg_q.angular_wake_speed <= cfg_i.data[WAKE_BITS-1:0];
        CFG_BLEND_START:  cfg_q.blend_start_time   <= cfg_i.data[TIME_BITS-1:0];
        CFG_SLEEP_END:    cfg_q.sleep_end_time     <= cfg_i.data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  rbst_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .ent_o    (push_ent)
  );

  rbst_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ent_i  (push_ent),
    .pop_i  (pop),
    .ent_o  (pop_ent),
    .stat_o (q_stat)
  );

  rbst_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .ent_i    (pop_ent),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .rsp_o    (rsp_o)
  );

endmodule

@@ design/rbst_checker.sv @@
// Port-level checker of the sleep tracker response channel, bound to the top level.
module rbst_checker import rbst_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic                  rsp_is_active_i,
  input logic [BLEND_BITS-1:0] rsp_blend_i,
  input logic [TIME_BITS-1:0]  rsp_idle_time_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable({rsp_is_active_i, rsp_blend_i, rsp_idle_time_i}))
    else $error("response changed while stalled");

  a_blend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_blend_i <= BLEND_ONE)
    else $error("blend above full activity");

  a_zero_time_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_idle_time_i == '0) |-> rsp_blend_i == BLEND_ONE)
    else $error("zero inactive time without full blend");

endmodule

bind rigid_body_sleep_tracker_unit rbst_checker u_rbst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_is_active_i (rsp_o.is_active),
  .rsp_blend_i     (rsp_o.blend),
  .rsp_idle_time_i (rsp_o.idle_time)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Randomized self-checking testbench of the rigid body sleep tracker, with a sleep-state predictor.
module tb_top;
  import rbst_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned IDLE_PCT      = 31;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum {
    MOTION_QUIET,
    MOTION_NEAR,
    MOTION_WILD
  } motion_style_e;

  typedef struct packed {
    logic [CMD_BITS-1:0]        cmd;
    logic [STEP_BITS-1:0]       step_time;
    logic signed [VEL_BITS-1:0] lin_x;
    logic signed [VEL_BITS-1:0] lin_y;
    logic signed [VEL_BITS-1:0] lin_z;
    logic signed [VEL_BITS-1:0] ang_x;
    logic signed [VEL_BITS-1:0] ang_y;
    logic signed [VEL_BITS-1:0] ang_z;
  } motion_t;

  typedef struct packed {
    logic                  is_active;
    logic [BLEND_BITS-1:0] blend;
    logic [TIME_BITS-1:0]  idle_time;
  } status_t;

  class sleep_state_scoreboard;
    cfg_t                 settings;
    logic [TIME_BITS-1:0] idle_time;
    logic                 active;
    status_t              expected_status_q[$];
    int unsigned          checked;
    int unsigned          asleep_seen;
    int unsigned          partial_seen;
    int unsigned          mismatches;
    int unsigned          cmd_seen [4];

    function new();
      settings.sleep_enable       = SLEEP_EN_RST;
      settings.linear_wake_speed  = WAKE_SPEED_RST;
      settings.angular_wake_speed = WAKE_SPEED_RST;
      settings.blend_start_time   = BLEND_START_RST;
      settings.sleep_end_time     = SLEEP_END_RST;
      idle_time    = '0;
      active       = 1'b1;
      checked      = 0;
      asleep_seen  = 0;
      partial_seen = 0;
      mismatches   = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    function void configure(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        CFG_SLEEP_ENABLE: settings.sleep_enable       = value[0];
        CFG_LINEAR_WAKE:  settings.linear_wake_speed  = value[WAKE_BITS-1:0];
        CFG_ANGULAR_WAKE: settings.angular_wake_speed = value[WAKE_BITS-1:0];
        CFG_BLEND_START:  settings.blend_start_time   = value[TIME_BITS-1:0];
        CFG_SLEEP_END:    settings.sleep_end_time     = value[TIME_BITS-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned speed_sq(logic signed [VEL_BITS-1:0] a,
                                       logic signed [VEL_BITS-1:0] b,
                                       logic signed [VEL_BITS-1:0] c);
      longint signed sa, sb, sc;
      sa = a;
      sb = b;
      sc = c;
      return longint'(sa * sa) + longint'(sb * sb) + longint'(sc * sc);
    endfunction

    function longint unsigned wake_sq(logic [WAKE_BITS-1:0] thr);
      longint unsigned w;
      w = thr;
      return w * w;
    endfunction

    function logic [BLEND_BITS-1:0] blend_now();
      longint unsigned t, s, e, full;
      t    = idle_time;
      s    = settings.blend_start_time;
      e    = settings.sleep_end_time;
      full = BLEND_ONE;
      if (t <= s) return BLEND_ONE;
      if (t >= e) return '0;
      return BLEND_BITS'(full - ((t - s) * full) / (e - s));
    endfunction

    function void note_request(motion_t r);
      longint unsigned grown;
      logic            moving;
      status_t         want;
      cmd_seen[r.cmd]++;
      case (r.cmd)
        CMD_TICK: begin
          if (!settings.sleep_enable) begin
            idle_time = '0;
            active    = 1'b1;
          end else begin
            moving = (speed_sq(r.lin_x, r.lin_y, r.lin_z) >
                      wake_sq(settings.linear_wake_speed)) ||
                     (speed_sq(r.ang_x, r.ang_y, r.ang_z) >
                      wake_sq(settings.angular_wake_speed));
            if (moving) begin
              idle_time = (idle_time > r.step_time) ? idle_time - r.step_time : '0;
            end else begin
              grown = idle_time + r.step_time;
              idle_time = (grown > settings.sleep_end_time) ?
                          settings.sleep_end_time : TIME_BITS'(grown);
            end
            active = idle_time < settings.sleep_end_time;
          end
        end
        CMD_ACTIVATE: begin
          idle_time = '0;
          active    = 1'b1;
        end
        CMD_DEACTIVATE: begin
          idle_time = DEACT_TIME;
          active    = 1'b0;
        end
        default: ;
      endcase
      want.is_active = active;
      want.blend     = blend_now();
      want.idle_time = idle_time;
      expected_status_q.push_back(want);
    endfunction

    function void check_status(logic act, logic [BLEND_BITS-1:0] bl,
                               logic [TIME_BITS-1:0] it);
      status_t want;
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%t: response with no request waiting: active %0b blend %0d idle %0d",
                   $time, act, bl, it);
        return;
      end
      want = expected_status_q.pop_front();
      checked++;
      if (!want.is_active) asleep_seen++;
      if (want.blend != '0 && want.blend != BLEND_ONE) partial_seen++;
      if (want.is_active !== act || want.blend !== bl || want.idle_time !== it) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%t: response %0d: active exp %0b got %0b, blend exp %0d got %0d, idle exp %0d got %0d",
                   $time, checked, want.is_active, act, want.blend, bl, want.idle_time, it);
      end
    endfunction

    function int unsigned pending();
      return expected_status_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        quiet_run;
  int unsigned stall_cycles = 0;
  int unsigned settings_applied = 0;

  sleep_state_scoreboard tracker = new();

  rbst_req_if req_if();
  rbst_rsp_if rsp_if();
  rbst_cfg_if cfg_if();

  rigid_body_sleep_tracker_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      tracker.check_status(rsp_if.is_active, rsp_if.blend, rsp_if.idle_time);
    rsp_if.ready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%t: no request or response moved for %0d cycles", $time, stall_cycles);
      $display("rigid_body_sleep_tracker_unit regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input motion_t r);
    while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= r.cmd;
    req_if.step_time <= r.step_time;
    req_if.lin_vel_x <= r.lin_x;
    req_if.lin_vel_y <= r.lin_y;
    req_if.lin_vel_z <= r.lin_z;
    req_if.ang_vel_x <= r.ang_x;
    req_if.ang_vel_y <= r.ang_y;
    req_if.ang_vel_z <= r.ang_z;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(r);
  endtask

  task automatic wait_for_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    tracker.configure(idx, value);
  endtask

  task automatic apply_settings(input logic en, input int unsigned lin, input int unsigned ang,
                                input int unsigned start, input int unsigned stop);
    wait_for_responses();
    write_register(CFG_SLEEP_ENABLE, CFG_DATA_BITS'(en));
    write_register(CFG_LINEAR_WAKE, CFG_DATA_BITS'(lin));
    write_register(CFG_ANGULAR_WAKE, CFG_DATA_BITS'(ang));
    write_register(CFG_BLEND_START, CFG_DATA_BITS'(start));
    write_register(CFG_SLEEP_END, CFG_DATA_BITS'(stop));
    cfg_if.valid <= 1'b0;
    settings_applied++;
  endtask

  function automatic motion_t make_motion(logic [CMD_BITS-1:0] cmd, int unsigned step,
                                          int lx, int ly, int lz, int ax, int ay, int az);
    motion_t r;
    r.cmd       = cmd;
    r.step_time = STEP_BITS'(step);
    r.lin_x     = VEL_BITS'(lx);
    r.lin_y     = VEL_BITS'(ly);
    r.lin_z     = VEL_BITS'(lz);
    r.ang_x     = VEL_BITS'(ax);
    r.ang_y     = VEL_BITS'(ay);
    r.ang_z     = VEL_BITS'(az);
    return r;
  endfunction

  function automatic logic signed [VEL_BITS-1:0] pick_component(int unsigned thr,
                                                                motion_style_e style);
    int unsigned                mag;
    logic signed [VEL_BITS-1:0] v;
    case (style)
      MOTION_QUIET: mag = $urandom_range(thr / 2);
      MOTION_NEAR:  mag = $urandom_range(thr, thr / 2);
      default:      return VEL_BITS'($urandom);
    endcase
    v = VEL_BITS'(mag);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic motion_t random_motion(int unsigned lin_thr, int unsigned ang_thr,
                                            int unsigned stop);
    motion_t       r;
    int unsigned   roll;
    int unsigned   step_cap;
    motion_style_e lin_style, ang_style;
    roll = $urandom_range(99);
    if (roll < 5)       r.cmd = CMD_ACTIVATE;
    else if (roll < 10) r.cmd = CMD_DEACTIVATE;
    else if (roll < 13) r.cmd = CMD_UNUSED;
    else                r.cmd = CMD_TICK;
    step_cap = (stop / 3 + 16 > 65535) ? 65535 : stop / 3 + 16;
    roll = $urandom_range(99);
    if (roll < 10)      r.step_time = STEP_BITS'($urandom);
    else if (roll < 20) r.step_time = STEP_BITS'($urandom_range(15));
    else                r.step_time = STEP_BITS'($urandom_range(step_cap));
    if ($urandom_range(99) < 55) begin
      lin_style = MOTION_QUIET;
      ang_style = MOTION_QUIET;
    end else begin
      lin_style = motion_style_e'($urandom_range(2));
      ang_style = motion_style_e'($urandom_range(2));
    end
    r.lin_x = pick_component(lin_thr, lin_style);
    r.lin_y = pick_component(lin_thr, lin_style);
    r.lin_z = pick_component(lin_thr, lin_style);
    r.ang_x = pick_component(ang_thr, ang_style);
    r.ang_y = pick_component(ang_thr, ang_style);
    r.ang_z = pick_component(ang_thr, ang_style);
    return r;
  endfunction

  task automatic run_phase(input logic en, input int unsigned lin, input int unsigned ang,
                           input int unsigned start, input int unsigned stop);
    int unsigned done_n;
    motion_t     r;
    apply_settings(en, lin, ang, start, stop);
    done_n = 0;
    while (done_n < PHASE_ITEMS) begin
      r = random_motion(lin, ang, stop);
      send_request(r);
      if (r.cmd != CMD_UNUSED) done_n++;
    end
  endtask

  initial begin
    int unsigned rand_start;
    rst_ni           = 1'b0;
    quiet_run        = 1'b0;
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_TICK;
    req_if.step_time = '0;
    req_if.lin_vel_x = '0;
    req_if.lin_vel_y = '0;
    req_if.lin_vel_z = '0;
    req_if.ang_vel_x = '0;
    req_if.ang_vel_y = '0;
    req_if.ang_vel_z = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_SLEEP_ENABLE;
    cfg_if.data      = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(make_motion(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 1000, 0, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 500, 0, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 65535, 0, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 100, 256, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 100, -257, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 65535, 0, 0, 0, 0, 0, 257));
    send_request(make_motion(CMD_TICK, 5, -32768, -32768, -32768, -32768, -32768, -32768));
    send_request(make_motion(CMD_TICK, 5, 32767, 32767, 32767, 32767, 32767, 32767));
    send_request(make_motion(CMD_ACTIVATE, 65535, -1, -1, -1, -1, -1, -1));
    send_request(make_motion(CMD_DEACTIVATE, 1234, 500, -500, 77, 9, -9, 3));
    send_request(make_motion(CMD_UNUSED, 65535, 32767, 32767, 32767, 32767, 32767, 32767));
    send_request(make_motion(CMD_TICK, 10, 0, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_DEACTIVATE, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 65535, 0, 300, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 65535, 0, 0, 0, 200, 200, 200));

    apply_settings(1'b1, 256, 256, 3000, 1000);
    send_request(make_motion(CMD_TICK, 900, 0, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 200, 0, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_DEACTIVATE, 0, 0, 0, 0, 0, 0, 0));

    apply_settings(1'b1, 0, 0, 0, 0);
    send_request(make_motion(CMD_TICK, 7, 0, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 7, 1, 0, 0, 0, 0, 0));

    apply_settings(1'b0, 32767, 32767, 0, 262143);
    send_request(make_motion(CMD_DEACTIVATE, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 100, 32767, 32767, 32767, 32767, 32767, 32767));

    apply_settings(1'b1, 32767, 32767, 0, 262143);
    send_request(make_motion(CMD_TICK, 65535, 32767, 0, 0, 0, 0, 0));
    send_request(make_motion(CMD_TICK, 65535, -32768, 0, 0, 0, 0, 0));

    run_phase(1'b1, 256, 256, 1024, 2048);
    quiet_run <= 1'b1;
    rand_start = $urandom_range(4096);
    run_phase(1'b1, $urandom_range(2000, 1), $urandom_range(2000, 1), rand_start,
              rand_start + $urandom_range(8192, 1));
    quiet_run <= 1'b0;
    run_phase(1'b1, 0, 32767, 512, 1024);
    run_phase(1'b1, 32767, 0, 0, 262143);
    run_phase(1'b1, 300, 300, 0, 0);
    run_phase(1'b1, 256, 512, 5000, 3000);
    run_phase(1'b0, 256, 256, 1024, 2048);
    run_phase(1'b1, $urandom_range(32767), $urandom_range(32767), $urandom_range(262143),
              $urandom_range(262143));

    wait_for_responses();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Drove %0d ticks, %0d activates, %0d deactivates, %0d unused codes over %0d settings.",
             tracker.cmd_seen[CMD_TICK], tracker.cmd_seen[CMD_ACTIVATE],
             tracker.cmd_seen[CMD_DEACTIVATE], tracker.cmd_seen[CMD_UNUSED], settings_applied);
    $display("Checked %0d responses (%0d asleep, %0d partial blend), %0d mismatches.",
             tracker.checked, tracker.asleep_seen, tracker.partial_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("rigid_body_sleep_tracker_unit regression: pass");
    end else begin
      $display("rigid_body_sleep_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule
